FILE: src/pfa_pkg.sv
package pfa_pkg;

  // frame and count widths
  localparam int FRAME_BITS = 40;
  localparam int COUNT_BITS = FRAME_BITS + 1;

  // freed frame stack
  localparam int STACK_DEPTH = 1024;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int FILL_BITS   = $clog2(STACK_DEPTH + 1);

  // usable memory regions
  localparam int NUM_REGIONS   = 3;
  localparam int REG_IDX_BITS  = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int STEP_BITS     = $clog2(NUM_REGIONS + 1);

  // configuration register map
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_BEGIN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_END   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_BASE = 3'd2;

  // request codes
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FRAMES = 2'd1;
  localparam logic [1:0] ST_STACK_FULL = 2'd2;
  localparam logic [1:0] ST_OVER_SIZE = 2'd3;

  typedef logic [FRAME_BITS-1:0]   frame_t;
  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [1:0]              code_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  typedef struct packed {
    frame_t frame_out;
    code_t  status;
    count_t free_frames;
  } result_t;

endpackage

FILE: src/pfa_if.sv
// request channel
interface pfa_req_if;
  import pfa_pkg::*;
  logic   valid;
  logic   ready;
  code_t  req_type;
  frame_t frame_in;
  modport source (output valid, output req_type, output frame_in, input ready);
  modport sink (input valid, input req_type, input frame_in, output ready);
endinterface

// result channel
interface pfa_res_if;
  import pfa_pkg::*;
  logic   valid;
  logic   ready;
  frame_t frame_out;
  code_t  status;
  count_t free_frames;
  modport source (output valid, output frame_out, output status, output free_frames,
                  input ready);
  modport sink (input valid, input frame_out, input status, input free_frames,
                output ready);
endinterface

// configuration write channel
interface pfa_cfg_if;
  import pfa_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  count_t   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/physical_frame_allocator.sv
// channel   dir  payload                              transaction when
// in_ch     in   req_type, frame_in                   valid && ready
// out_ch    out  frame_out, status, free_frames       valid && ready
// cfg_ch    in   index, data                          valid && ready (ready always high)
//
// allocate and free may follow back to back while the skid entry is empty; the
// stack top comes from a registered ram read plus a one-entry push bypass.
// restart runs in steps (overlaps, one region summed per cycle, final size);
// in_ch.ready is low from its transaction through the final size step.
// a two-entry output stage (result register and skid) keeps in_ch.ready free of
// out_ch.ready; reset is synchronous, active low, and needs no clearing pass.
module physical_frame_allocator (
  input  logic  clk,
  input  logic  rst_n,
  pfa_req_if.sink   in_ch,
  pfa_res_if.source out_ch,
  pfa_cfg_if.sink   cfg_ch
);
  import pfa_pkg::*;

  // configuration registers
  count_t range_begin_r;
  count_t range_end_r;
  count_t reg_lo_r [NUM_REGIONS];
  count_t reg_hi_r [NUM_REGIONS];

  // allocator state
  count_t                  free_cnt_r, free_cnt_nxt;
  count_t                  bump_r, bump_nxt;
  logic [REG_IDX_BITS-1:0] ridx_r, ridx_nxt;
  count_t                  range_size_r;
  logic [FILL_BITS-1:0]    fill_r, fill_nxt;
  logic                    byp_r;
  frame_t                  byp_val_r;

  // restart sequencer
  logic                    busy_r;
  logic [STEP_BITS-1:0]    step_r;
  count_t                  acc_r;
  count_t                  ov_r [NUM_REGIONS];

  // output stage
  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;

  logic                    in_acc;
  logic                    rst_start;
  logic                    rst_finish;
  logic                    prod;
  result_t                 res;
  logic                    push;
  frame_t                  top;
  frame_t                  ram_q;
  logic [FILL_BITS-1:0]    rd_tmp;
  logic [STACK_AW-1:0]     rd_addr;
  count_t                  hi_sel;
  count_t                  bump_frame;
  logic                    jump;
  logic [REG_IDX_BITS-1:0] ridx_inc;
  logic [REG_IDX_BITS-1:0] ridx_search;
  count_t                  ov_calc [NUM_REGIONS];
  count_t                  lo_sel;
  logic [COUNT_BITS:0]     acc_sum;
  logic                    out_free;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign rst_start  = in_acc && (in_ch.req_type == REQ_RESTART);
  assign rst_finish = busy_r && (step_r == STEP_BITS'(NUM_REGIONS));
  assign prod       = (in_acc && (in_ch.req_type != REQ_RESTART)) || rst_finish;

  assign in_ch.ready = !busy_r && !skid_valid_r;
  assign cfg_ch.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_begin_r <= '0;
      range_end_r   <= '0;
      for (int r = 0; r < NUM_REGIONS; r++) begin
        reg_lo_r[r] <= '0;
        reg_hi_r[r] <= '0;
      end
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_RANGE_BEGIN) begin
        range_begin_r <= cfg_ch.data;
      end
      if (cfg_ch.index == CFG_RANGE_END) begin
        range_end_r <= cfg_ch.data;
      end
      for (int r = 0; r < NUM_REGIONS; r++) begin
        if (cfg_ch.index == CFG_REGION_BASE + CFG_IDX_BITS'(2 * r)) begin
          reg_lo_r[r] <= cfg_ch.data;
        end
        if (cfg_ch.index == CFG_REGION_BASE + CFG_IDX_BITS'(2 * r + 1)) begin
          reg_hi_r[r] <= cfg_ch.data;
        end
      end
    end
  end

  // stack top: just-pushed value or the prefetched ram entry
  assign top = byp_r ? byp_val_r : ram_q;

  // bump pointer step with region jump
  assign ridx_inc   = ridx_r + REG_IDX_BITS'(1);
  assign hi_sel     = reg_hi_r[ridx_r];
  assign jump       = (ridx_r < REG_IDX_BITS'(NUM_REGIONS - 1)) && (bump_r == hi_sel);
  assign bump_frame = jump ? reg_lo_r[ridx_inc] : bump_r;

  // restart: per-region overlap with the allocation range
  always_comb begin
    count_t lo, hi;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      lo = (range_begin_r > reg_lo_r[r]) ? range_begin_r : reg_lo_r[r];
      hi = (range_end_r < reg_hi_r[r]) ? range_end_r : reg_hi_r[r];
      ov_calc[r] = (hi > lo) ? (hi - lo) : '0;
    end
  end

  // restart: first region ending above range_begin, else the last one
  always_comb begin
    ridx_search = REG_IDX_BITS'(NUM_REGIONS - 1);
    for (int r = NUM_REGIONS - 1; r >= 0; r--) begin
      if (reg_hi_r[r] > range_begin_r) begin
        ridx_search = REG_IDX_BITS'(r);
      end
    end
  end

  // restart: bump start and saturating capacity sum
  assign lo_sel  = reg_lo_r[ridx_r];
  assign acc_sum = {1'b0, acc_r} + {1'b0, ov_r[step_r[REG_IDX_BITS-1:0]]};

  // request decode and next state
  always_comb begin
    free_cnt_nxt = free_cnt_r;
    bump_nxt     = bump_r;
    ridx_nxt     = ridx_r;
    fill_nxt     = fill_r;
    push         = 1'b0;
    res.frame_out = '0;
    res.status    = ST_OK;

    if (in_acc) begin
      case (in_ch.req_type)
        REQ_ALLOC: begin
          if (free_cnt_r == '0) begin
            res.status = ST_NO_FRAMES;
          end else if (fill_r != '0) begin
            fill_nxt      = fill_r - FILL_BITS'(1);
            res.frame_out = top;
            free_cnt_nxt  = free_cnt_r - COUNT_BITS'(1);
          end else begin
            if (jump) begin
              ridx_nxt = ridx_inc;
            end
            res.frame_out = bump_frame[FRAME_BITS-1:0];
            bump_nxt      = bump_frame + COUNT_BITS'(1);
            free_cnt_nxt  = free_cnt_r - COUNT_BITS'(1);
          end
        end
        REQ_FREE: begin
          if (free_cnt_r >= range_size_r) begin
            res.status = ST_OVER_SIZE;
          end else if (fill_r == FILL_BITS'(STACK_DEPTH)) begin
            res.status = ST_STACK_FULL;
          end else begin
            push         = 1'b1;
            fill_nxt     = fill_r + FILL_BITS'(1);
            free_cnt_nxt = free_cnt_r + COUNT_BITS'(1);
          end
        end
        REQ_RESTART: begin
          ridx_nxt = ridx_search;
        end
        default: begin
        end
      endcase
    end

    // first sequencer step places the bump pointer
    if (busy_r && (step_r == '0)) begin
      bump_nxt = (range_begin_r < lo_sel) ? lo_sel : range_begin_r;
    end

    if (rst_finish) begin
      fill_nxt     = '0;
      free_cnt_nxt = acc_r;
    end

    res.free_frames = free_cnt_nxt;
  end

  // prefetch the entry that becomes the new top
  assign rd_tmp  = fill_nxt - FILL_BITS'(1);
  assign rd_addr = rd_tmp[STACK_AW-1:0];

  pfa_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (fill_r[STACK_AW-1:0]),
    .wdata (in_ch.frame_in),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // allocator and sequencer control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r   <= '0;
      bump_r       <= '0;
      ridx_r       <= '0;
      range_size_r <= '0;
      fill_r       <= '0;
      byp_r        <= 1'b0;
      busy_r       <= 1'b0;
      step_r       <= '0;
      acc_r        <= '0;
    end else begin
      free_cnt_r <= free_cnt_nxt;
      bump_r     <= bump_nxt;
      ridx_r     <= ridx_nxt;
      fill_r     <= fill_nxt;
      byp_r      <= push;
      if (rst_start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        acc_r  <= '0;
      end else if (rst_finish) begin
        busy_r       <= 1'b0;
        range_size_r <= (range_end_r > bump_r) ? (range_end_r - bump_r) : '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_BITS'(1);
        acc_r  <= acc_sum[COUNT_BITS] ? '1 : acc_sum[COUNT_BITS-1:0];
      end
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (push) begin
      byp_val_r <= in_ch.frame_in;
    end
    if (rst_start) begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
        ov_r[r] <= ov_calc[r];
      end
    end
  end

  // output register with skid entry
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= prod;
      end
    end else if (prod) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (prod) begin
        out_data_r <= res;
      end
    end else if (prod) begin
      skid_data_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_out   = out_data_r.frame_out;
  assign out_ch.status      = out_data_r.status;
  assign out_ch.free_frames = out_data_r.free_frames;

endmodule

FILE: src/pfa_ram.sv
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
